### design/spq_pkg.sv
// Shared types and constants for the stable priority queue unit.
package spq_pkg;

	// Queue geometry
	localparam int QUEUE_DEPTH   = 16;
	localparam int PRIORITY_BITS = 8;
	localparam int ID_W          = 16;
	localparam int PRIO_PORT_W   = 8;
	localparam int PRIO_W        = (PRIORITY_BITS < PRIO_PORT_W) ? PRIORITY_BITS : PRIO_PORT_W;
	localparam int IDX_W         = $clog2(QUEUE_DEPTH);
	localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);

	// Command codes
	localparam logic [1:0] MODE_ENQ = 2'd0;
	localparam logic [1:0] MODE_DEQ = 2'd1;
	localparam logic [1:0] MODE_UPD = 2'd2;

	// Status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_EMPTY    = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	// One stored queue entry
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [PRIO_W-1:0] prio;
	} spq_entry_t;

	// Flags from the shared compare unit
	typedef struct packed {
		logic id_eq;
		logic prio_ge;
	} spq_cmp_t;

endpackage

### design/spq_cmp.sv
// Shared compare unit: matches a stored entry against the transaction key.
module spq_cmp
	import spq_pkg::*;
(
	input  spq_entry_t        entry,
	input  logic [ID_W-1:0]   key_id,
	input  logic [PRIO_W-1:0] key_prio,
	output spq_cmp_t          flags
);

	// Id match for search, priority order for placement
	always_comb begin
		flags.id_eq   = (entry.id == key_id);
		flags.prio_ge = (entry.prio >= key_prio);
	end

endmodule

### design/stable_priority_queue_unit.sv
// Stable priority queue: sorted entry memory stepped by a small sequencer.
// Full, empty and unused commands finish from the idle state without a walk; enqueue,
// dequeue and update walk the entry memory (one memory entry visited per cycle).
// Throughput: one transaction at a time; busy stays high until the result strobe.
// done pulses for exactly one cycle with the result; the receiver cannot stall it.
// Reset (arst_n low, asynchronous) empties the queue; entry memory is not cleared.
module stable_priority_queue_unit
	import spq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [15:0] process_id,
	input  logic [7:0]  priority_req,
	output logic        done,
	output logic [1:0]  status,
	output logic [15:0] out_id,
	output logic [7:0]  out_priority,
	output logic [4:0]  occupancy
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DEQ_HEAD,
		S_SRCH,
		S_REM_START,
		S_REM,
		S_REM_END,
		S_INS_START,
		S_INS_CHK
	} state_t;

	state_t            state_q;
	logic [1:0]        mode_q;
	logic [ID_W-1:0]   id_q;
	logic [PRIO_W-1:0] prio_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  ptr_q;
	logic              done_q;
	logic [1:0]        status_q;
	logic [ID_W-1:0]   res_id_q;
	logic [PRIO_W-1:0] res_prio_q;

	// Entry memory
	spq_entry_t        mem_q [QUEUE_DEPTH];
	spq_entry_t        rd_q;
	logic [IDX_W-1:0]  rd_addr;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	spq_entry_t        wr_data;
	spq_entry_t        new_entry;
	spq_cmp_t          cmp;

	logic [CNT_W-1:0]  ptr_m1;
	logic [CNT_W-1:0]  ptr_m2;
	logic [CNT_W-1:0]  ptr_p1;
	logic [CNT_W-1:0]  ptr_p2;

	assign ptr_m1    = ptr_q - CNT_W'(1);
	assign ptr_m2    = ptr_q - CNT_W'(2);
	assign ptr_p1    = ptr_q + CNT_W'(1);
	assign ptr_p2    = ptr_q + CNT_W'(2);
	assign new_entry = '{id: id_q, prio: prio_q};

	spq_cmp u_cmp (
		.entry    (rd_q),
		.key_id   (id_q),
		.key_prio (prio_q),
		.flags    (cmp)
	);

	// Memory port decode per sequencer step
	always_comb begin
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = ptr_q[IDX_W-1:0];
		wr_data = new_entry;
		case (state_q)
			S_INS_START: begin
				if (ptr_q == '0) begin
					wr_en = 1'b1;
				end else begin
					rd_addr = ptr_m1[IDX_W-1:0];
				end
			end
			S_INS_CHK: begin
				wr_en = 1'b1;
				if (!cmp.prio_ge) begin
					wr_data = rd_q;
					rd_addr = ptr_m2[IDX_W-1:0];
				end
			end
			S_REM_START: rd_addr = ptr_p1[IDX_W-1:0];
			S_REM: begin
				wr_en   = 1'b1;
				wr_data = rd_q;
				rd_addr = ptr_p2[IDX_W-1:0];
			end
			S_SRCH: rd_addr = ptr_p1[IDX_W-1:0];
			default: rd_addr = '0;
		endcase
	end

	// At most one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_q <= mem_q[rd_addr];
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			mode_q     <= MODE_ENQ;
			id_q       <= '0;
			prio_q     <= '0;
			cnt_q      <= '0;
			ptr_q      <= '0;
			done_q     <= 1'b0;
			status_q   <= ST_OK;
			res_id_q   <= '0;
			res_prio_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						mode_q     <= mode;
						id_q       <= process_id;
						prio_q     <= priority_req[PRIO_W-1:0];
						res_id_q   <= '0;
						res_prio_q <= '0;
						case (mode)
							MODE_ENQ: begin
								ptr_q <= cnt_q;
								if (cnt_q == CNT_W'(QUEUE_DEPTH)) begin
									status_q <= ST_FULL;
									done_q   <= 1'b1;
								end else begin
									status_q <= ST_OK;
									done_q   <= 1'b0;
									state_q  <= S_INS_START;
								end
							end
							MODE_DEQ: begin
								ptr_q <= '0;
								if (cnt_q == '0) begin
									status_q <= ST_EMPTY;
									done_q   <= 1'b1;
								end else begin
									status_q <= ST_OK;
									done_q   <= 1'b0;
									state_q  <= S_DEQ_HEAD;
								end
							end
							MODE_UPD: begin
								ptr_q <= '0;
								if (cnt_q == '0) begin
									status_q <= ST_NOTFOUND;
									done_q   <= 1'b1;
								end else begin
									status_q <= ST_OK;
									done_q   <= 1'b0;
									state_q  <= S_SRCH;
								end
							end
							default: begin
								ptr_q    <= '0;
								status_q <= ST_OK;
								done_q   <= 1'b1;
							end
						endcase
					end else begin
						done_q <= 1'b0;
					end
				end
				// Head entry is on the read port; capture it, then close the gap
				S_DEQ_HEAD: begin
					done_q     <= 1'b0;
					res_id_q   <= rd_q.id;
					res_prio_q <= rd_q.prio;
					state_q    <= S_REM_START;
				end
				// Walk from the head looking for the first matching id
				S_SRCH: begin
					if (cmp.id_eq) begin
						done_q  <= 1'b0;
						state_q <= S_REM_START;
					end else if (ptr_p1 >= cnt_q) begin
						status_q <= ST_NOTFOUND;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						done_q <= 1'b0;
						ptr_q  <= ptr_p1;
					end
				end
				S_REM_START: begin
					done_q <= 1'b0;
					if (ptr_p1 >= cnt_q) begin
						state_q <= S_REM_END;
					end else begin
						state_q <= S_REM;
					end
				end
				// Shift the tail down one slot per cycle
				S_REM: begin
					done_q <= 1'b0;
					ptr_q  <= ptr_p1;
					if (ptr_p2 >= cnt_q) begin
						state_q <= S_REM_END;
					end
				end
				S_REM_END: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (mode_q == MODE_DEQ) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						done_q  <= 1'b0;
						ptr_q   <= cnt_q - CNT_W'(1);
						state_q <= S_INS_START;
					end
				end
				// Free slot at ptr; place here if at head, else look at the entry above
				S_INS_START: begin
					if (ptr_q == '0) begin
						cnt_q   <= cnt_q + CNT_W'(1);
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						done_q  <= 1'b0;
						state_q <= S_INS_CHK;
					end
				end
				// Stop behind an equal or higher priority, otherwise move it down
				S_INS_CHK: begin
					if (cmp.prio_ge) begin
						cnt_q   <= cnt_q + CNT_W'(1);
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						done_q <= 1'b0;
						ptr_q  <= ptr_m1;
						if (ptr_m1 == '0) begin
							state_q <= S_INS_START;
						end
					end
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign status       = status_q;
	assign out_id       = res_id_q;
	assign out_priority = PRIO_PORT_W'(res_prio_q);
	assign occupancy    = 5'(cnt_q);

endmodule
